[hdl/icon_pixel_effect_pipeline_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the icon pixel effect pipeline
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ICON_PIXEL_EFFECT_PIPELINE_CORE_MACROS_SVH
`define ICON_PIXEL_EFFECT_PIPELINE_CORE_MACROS_SVH

// check a consequent in the same cycle as its trigger
`define IPE_ASSERT_NOW(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// check a consequent in the cycle after its trigger
`define IPE_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

[hdl/ipe_pkg.sv]
// ----------------------------------------------------------------------------
// ipe_pkg
// Types, constants and pixel helper functions of the pixel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipe_pkg;

   // pipeline depth, input register to output register
   localparam int NUM_STAGES = 6;

   typedef logic [7:0] chan_type;
   // index 0 red, 1 green, 2 blue
   typedef chan_type [2:0] rgb_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_SPOT = 2'd1,
      MODE_TINT = 2'd2,
      MODE_GREY = 2'd3
   } mode_type;

   // register indexes on the csr port
   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_SAT      = 3'd1;
   localparam logic [2:0] REG_BRIGHT   = 3'd2;
   localparam logic [2:0] REG_LIGHTEN  = 3'd3;
   localparam logic [2:0] REG_TINT     = 3'd4;

   localparam int CSR_DATA_W = 24;

   // luma weights
   localparam logic [15:0] LUMA_R = 16'd77;
   localparam logic [15:0] LUMA_G = 16'd150;
   localparam logic [15:0] LUMA_B = 16'd28;

   localparam int       CHAN_MAX_I = 255;
   localparam chan_type CHAN_MAX   = 8'hFF;
   localparam chan_type SPOT_ADD   = 8'd24;

   // greyscale blend runs with saturation 0 and full darken factor
   localparam logic [15:0] GREY_WEIGHT =
      16'(((CHAN_MAX_I - 0) * CHAN_MAX_I) >> 8);

   // register file contents plus derived blend coefficients
   typedef struct packed {
      mode_type mode;
      chan_type lighten;
      rgb_type  tint;
      chan_type keep_w;     // weight of the original channel
      chan_type luma_w;     // weight of the luma term
      logic     blend_en;
   } cfg_type;

   // weighted luma, (77 r + 150 g + 28 b) >> 8
   function automatic chan_type luma(input rgb_type p);
      logic [15:0] sum;
      begin
         sum = {8'd0, p[0]} * LUMA_R + {8'd0, p[1]} * LUMA_G + {8'd0, p[2]} * LUMA_B;
         return sum[15:8];
      end
   endfunction

   // c + amt + c / 8, clamped to full scale
   function automatic chan_type boost(input chan_type c, input chan_type amt);
      logic [9:0] sum;
      begin
         sum = {2'b00, c} + {2'b00, amt} + {5'd0, c[7:3]};
         return (sum > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum[7:0];
      end
   endfunction

   // (c * t) >> 8
   function automatic chan_type scale(input chan_type c, input chan_type t);
      logic [15:0] prod;
      begin
         prod = {8'd0, c} * {8'd0, t};
         return prod[15:8];
      end
   endfunction

endpackage

`default_nettype wire

[hdl/ipe_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ipe_cfg_regs
// Control registers of the pixel pipeline and the blend coefficients
// derived from them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipe_cfg_regs (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire  [2:0]                         csr_index,
   input  wire  [ipe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ipe_pkg::cfg_type                   cfg
);

   ipe_pkg::mode_type mode_ff;
   ipe_pkg::chan_type sat_ff;
   ipe_pkg::chan_type bright_ff;
   ipe_pkg::chan_type lighten_ff;
   logic [23:0]       tint_ff;

   ipe_pkg::chan_type keep_w_ff,   keep_w_in;
   ipe_pkg::chan_type luma_w_ff,   luma_w_in;
   logic              blend_en_ff, blend_en_in;

   logic [15:0] keep_prod;
   logic [15:0] luma_prod;

   // write one register per beat, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ipe_pkg::MODE_NONE;
         sat_ff     <= ipe_pkg::CHAN_MAX;
         bright_ff  <= ipe_pkg::CHAN_MAX;
         lighten_ff <= 8'd0;
         tint_ff    <= 24'hFFFFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            ipe_pkg::REG_MODE:    mode_ff    <= ipe_pkg::mode_type'(csr_wdata[1:0]);
            ipe_pkg::REG_SAT:     sat_ff     <= csr_wdata[7:0];
            ipe_pkg::REG_BRIGHT:  bright_ff  <= csr_wdata[7:0];
            ipe_pkg::REG_LIGHTEN: lighten_ff <= csr_wdata[7:0];
            ipe_pkg::REG_TINT:    tint_ff    <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // derive the blend weights from saturation and darken factor
   always_comb begin
      keep_prod   = {8'd0, sat_ff} * {8'd0, bright_ff};
      luma_prod   = {8'd0, ipe_pkg::CHAN_MAX - sat_ff} * {8'd0, bright_ff};
      keep_w_in   = keep_prod[15:8];
      luma_w_in   = luma_prod[15:8];
      blend_en_in = (sat_ff != ipe_pkg::CHAN_MAX) || (bright_ff != ipe_pkg::CHAN_MAX) ||
                    (mode_ff == ipe_pkg::MODE_NONE);
   end

   // hold the derived weights in registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_w_ff   <= 8'd254;
         luma_w_ff   <= 8'd0;
         blend_en_ff <= 1'b1;
      end else begin
         keep_w_ff   <= keep_w_in;
         luma_w_ff   <= luma_w_in;
         blend_en_ff <= blend_en_in;
      end
   end

   always_comb begin
      cfg.mode     = mode_ff;
      cfg.lighten  = lighten_ff;
      cfg.tint[0]  = tint_ff[23:16];
      cfg.tint[1]  = tint_ff[15:8];
      cfg.tint[2]  = tint_ff[7:0];
      cfg.keep_w   = keep_w_ff;
      cfg.luma_w   = luma_w_ff;
      cfg.blend_en = blend_en_ff;
   end

endmodule

`default_nettype wire

[hdl/icon_pixel_effect_pipeline_core.sv]
// Icon pixel effect pipeline: one RGBA pixel in, one RGBA pixel out, one pixel
// per clock sustained while rsp_tready stays high. The six register stages are:
// mode effect (spotlight or tint), greyscale scaling, greyscale tint, luma,
// saturation and brightness blend, lighten. Each stage advances when it is
// empty or the stage after it advances, so bubbles collapse and req_tready only
// drops when all six stages hold pixels and rsp_tready is low. Configuration is
// read by each stage as a pixel passes it, so a write can also affect pixels
// already in the pipeline; the blend weights are derived through a register.
// ----------------------------------------------------------------------------
// icon_pixel_effect_pipeline_core
// Streaming RGBA spotlight, tint, greyscale, saturation/brightness blend and lighten pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "icon_pixel_effect_pipeline_core_macros.svh"

module icon_pixel_effect_pipeline_core (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [31:0]                       req_tdata,   // red_in, green_in, blue_in, alpha_in
   // response channel
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [31:0]                       rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   // configuration port
   input  wire                               csr_we,
   input  wire  [2:0]                        csr_index,
   input  wire  [ipe_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int LAST = ipe_pkg::NUM_STAGES - 1;

   ipe_pkg::cfg_type cfg;

   logic [ipe_pkg::NUM_STAGES-1:0] vld_ff;
   logic [ipe_pkg::NUM_STAGES-1:0] en;

   ipe_pkg::chan_type alpha_ff [ipe_pkg::NUM_STAGES];

   ipe_pkg::rgb_type  in_pix;
   ipe_pkg::rgb_type  s0_pix_ff, s0_pix_in;
   ipe_pkg::chan_type s0_luma_ff;
   ipe_pkg::rgb_type  s1_pix_ff;
   ipe_pkg::chan_type s1_grey_ff, s1_grey_in;
   ipe_pkg::rgb_type  s2_pix_ff, s2_pix_in;
   ipe_pkg::rgb_type  s3_pix_ff;
   ipe_pkg::chan_type s3_luma_ff;
   ipe_pkg::rgb_type  s4_pix_ff, s4_pix_in;
   ipe_pkg::rgb_type  s5_pix_ff, s5_pix_in;

   logic [15:0] grey_prod;
   logic [16:0] mix_sum [3];

   ipe_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance a stage when it is empty or its successor advances
   always_comb begin
      en[LAST] = !vld_ff[LAST] || rsp_tready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k + 1];
      end
   end

   assign req_tready = en[0];

   // move valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < ipe_pkg::NUM_STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k - 1];
            end
         end
      end
   end

   // carry alpha alongside the color channels
   always_ff @(posedge clock) begin
      if (en[0]) begin
         alpha_ff[0] <= req_tdata[31:24];
      end
      for (int k = 1; k < ipe_pkg::NUM_STAGES; k++) begin
         if (en[k]) begin
            alpha_ff[k] <= alpha_ff[k - 1];
         end
      end
   end

   // stage 0: spotlight or tint, and luma for the greyscale path
   always_comb begin
      in_pix[0] = req_tdata[7:0];
      in_pix[1] = req_tdata[15:8];
      in_pix[2] = req_tdata[23:16];
      for (int c = 0; c < 3; c++) begin
         unique case (cfg.mode)
            ipe_pkg::MODE_SPOT: s0_pix_in[c] = ipe_pkg::boost(in_pix[c], ipe_pkg::SPOT_ADD);
            ipe_pkg::MODE_TINT: s0_pix_in[c] = ipe_pkg::scale(in_pix[c], cfg.tint[c]);
            ipe_pkg::MODE_NONE,
            ipe_pkg::MODE_GREY: s0_pix_in[c] = in_pix[c];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_pix_ff  <= s0_pix_in;
         s0_luma_ff <= ipe_pkg::luma(in_pix);
      end
   end

   // stage 1: scale luma to the greyscale level
   always_comb begin
      grey_prod  = {8'd0, s0_luma_ff} * ipe_pkg::GREY_WEIGHT;
      s1_grey_in = grey_prod[15:8];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_pix_ff  <= s0_pix_ff;
         s1_grey_ff <= s1_grey_in;
      end
   end

   // stage 2: tint the greyscale level in greyscale mode
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s2_pix_in[c] = (cfg.mode == ipe_pkg::MODE_GREY) ?
                        ipe_pkg::scale(s1_grey_ff, cfg.tint[c]) : s1_pix_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_pix_ff <= s2_pix_in;
      end
   end

   // stage 3: luma of the effect result
   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_pix_ff  <= s2_pix_ff;
         s3_luma_ff <= ipe_pkg::luma(s2_pix_ff);
      end
   end

   // stage 4: saturation and brightness blend
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mix_sum[c]   = 17'({8'd0, cfg.luma_w} * {8'd0, s3_luma_ff}) +
                        17'({8'd0, cfg.keep_w} * {8'd0, s3_pix_ff[c]});
         s4_pix_in[c] = cfg.blend_en ? mix_sum[c][15:8] : s3_pix_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_pix_ff <= s4_pix_in;
      end
   end

   // stage 5: lighten into the output register
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s5_pix_in[c] = (cfg.lighten != 8'd0) ?
                        ipe_pkg::boost(s4_pix_ff[c], cfg.lighten) : s4_pix_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_pix_ff <= s5_pix_in;
      end
   end

   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = {alpha_ff[LAST], s5_pix_ff[2], s5_pix_ff[1], s5_pix_ff[0]};

   // checks
   `IPE_ASSERT_NOW(a_ready_only_when_full, !req_tready, (&vld_ff) && !rsp_tready, "request stalled with room in the pipeline")
   `IPE_ASSERT_NEXT(a_lighten_off_passes, en[5] && vld_ff[4] && (cfg.lighten == 8'd0), s5_pix_ff == $past(s4_pix_ff), "output stage altered pixel with lighten off")
   `IPE_ASSERT_NOW(a_blend_weights_bounded, 1'b1, ({1'b0, cfg.keep_w} + {1'b0, cfg.luma_w}) <= 9'd255, "blend weights exceed full scale")

endmodule

`default_nettype wire
